>>> hw/rtl/ffrs_pkg.sv
// shared types, constants and coefficient table of the fuzz rim shade unit
package ffrs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_RED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_GREEN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_BLUE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT    = 3'd4;

    localparam logic [CFG_DATA_W-1:0] COLOR_RESET    = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] STRENGTH_RESET = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] EXPONENT_RESET = 16'd20480;

    localparam int DOT_STAGES   = 2;
    localparam int LOG_STAGES   = 17;
    localparam int EXP_MUL      = 16;
    localparam int EXP_STAGES   = EXP_MUL + 2;
    localparam int COLOR_STAGES = 3;

    localparam logic [30:0] ACC_ONE = 31'h4000_0000;

    typedef struct packed {
        logic [15:0] color_red;
        logic [15:0] color_green;
        logic [15:0] color_blue;
        logic [15:0] strength;
        logic [15:0] sharpness_exponent;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
    } sample_t;

    typedef struct packed {
        logic        zero;
        logic [16:0] base;
    } base_word_t;

    typedef struct packed {
        logic        zero;
        logic [20:0] neg;
    } log_word_t;

    typedef struct packed {
        logic [15:0] fuzz_red;
        logic [15:0] fuzz_green;
        logic [15:0] fuzz_blue;
    } rgb_t;

    typedef logic [16:1][30:0] coef_table_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bw;
        x   = x_in;
        res = '0;
        bw  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + bw)
            begin
                x   = x - (res + bw);
                res = (res >> 1) + bw;
            end
            else
            begin
                res = res >> 1;
            end
            bw = bw >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-i) in q.30, each root taken from the one before
    function automatic coef_table_t exp2_coef_table();
        coef_table_t tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int i = 1; i <= 16; i++)
        begin
            tab[i] = c[30:0];
            c      = isqrt64(c << 30);
        end
        return tab;
    endfunction

    localparam coef_table_t EXP2_COEF = exp2_coef_table();

endpackage

>>> hw/rtl/fresnel_fuzz_rim_shade_unit.sv
// fresnel fuzz rim shade unit: configuration registers and pipeline top level
// throughput: one word per cycle without output stall, set by the single-multiplier
// log2 and exp2 stages
// every stage holds its word under output stall, empty stages keep filling
// reset clears all valid bits and loads the register defaults (colors and strength
// 1.0, exponent 5.0)
module fresnel_fuzz_rim_shade_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ffrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ffrs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [15:0]                 normal_x,
    input  logic signed [15:0]                 normal_y,
    input  logic signed [15:0]                 normal_z,
    input  logic signed [15:0]                 view_x,
    input  logic signed [15:0]                 view_y,
    input  logic signed [15:0]                 view_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [15:0]                        fuzz_red,
    output logic [15:0]                        fuzz_green,
    output logic [15:0]                        fuzz_blue
);
    import ffrs_pkg::*;

    cfg_t       cfg_reg;
    sample_t    sample;
    base_word_t base_word;
    log_word_t  log_word;
    rgb_t       rgb_word;
    logic       dot_valid;
    logic       dot_ready;
    logic       log_valid;
    logic       log_ready;
    logic       exp_valid;
    logic       exp_ready;
    logic [30:0] fresnel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_red          <= COLOR_RESET;
            cfg_reg.color_green        <= COLOR_RESET;
            cfg_reg.color_blue         <= COLOR_RESET;
            cfg_reg.strength           <= STRENGTH_RESET;
            cfg_reg.sharpness_exponent <= EXPONENT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLOR_RED:   cfg_reg.color_red          <= cfg_data;
                REG_COLOR_GREEN: cfg_reg.color_green        <= cfg_data;
                REG_COLOR_BLUE:  cfg_reg.color_blue         <= cfg_data;
                REG_STRENGTH:    cfg_reg.strength           <= cfg_data;
                REG_EXPONENT:    cfg_reg.sharpness_exponent <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign sample.normal_x = normal_x;
    assign sample.normal_y = normal_y;
    assign sample.normal_z = normal_z;
    assign sample.view_x   = view_x;
    assign sample.view_y   = view_y;
    assign sample.view_z   = view_z;

    ffrs_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (sample),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_word  (base_word)
    );

    ffrs_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_word   (base_word),
        .out_valid (log_valid),
        .out_ready (log_ready),
        .out_word  (log_word)
    );

    ffrs_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (log_valid),
        .in_ready  (log_ready),
        .in_word   (log_word),
        .out_valid (exp_valid),
        .out_ready (exp_ready),
        .fresnel   (fresnel)
    );

    ffrs_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (exp_valid),
        .in_ready  (exp_ready),
        .fresnel   (fresnel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (rgb_word)
    );

    assign fuzz_red   = rgb_word.fuzz_red;
    assign fuzz_green = rgb_word.fuzz_green;
    assign fuzz_blue  = rgb_word.fuzz_blue;

    a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input blocked while the output side drains");

endmodule

>>> hw/rtl/ffrs_dot.sv
// dot product of normal and view, clamp and base of the power
module ffrs_dot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffrs_pkg::sample_t    in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ffrs_pkg::base_word_t out_word
);
    import ffrs_pkg::*;

    localparam logic signed [33:0] DOT_ONE = 34'sh0_4000_0000;

    logic [DOT_STAGES-1:0] valid_reg;
    logic [DOT_STAGES:0]   ready_chain;

    logic signed [31:0] prod_reg [3];
    logic signed [31:0] prod_next [3];
    logic [16:0]        base_reg;
    logic [16:0]        base_next;
    logic               zero_reg;
    logic               zero_next;
    logic signed [33:0] dot_sum;
    logic [16:0]        clamp_t;

    always_comb
    begin
        ready_chain[DOT_STAGES] = out_ready;
        for (int s = DOT_STAGES - 1; s >= 0; s--)
        begin
            ready_chain[s] = !valid_reg[s] || ready_chain[s+1];
        end
    end

    assign in_ready = ready_chain[0];

    always_comb
    begin
        prod_next[0] = 32'(in_word.normal_x * in_word.view_x);
        prod_next[1] = 32'(in_word.normal_y * in_word.view_y);
        prod_next[2] = 32'(in_word.normal_z * in_word.view_z);
        dot_sum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        if (dot_sum <= 34'sd0)
        begin
            clamp_t = '0;
        end
        else if (dot_sum >= DOT_ONE)
        begin
            clamp_t = 17'h1_0000;
        end
        else
        begin
            clamp_t = 17'(dot_sum[29:14]);
        end
        base_next = 17'h1_0000 - clamp_t;
        zero_next = (base_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready_chain[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (ready_chain[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_chain[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (ready_chain[1])
        begin
            base_reg <= base_next;
            zero_reg <= zero_next;
        end
    end

    assign out_valid     = valid_reg[DOT_STAGES-1];
    assign out_word.zero = zero_reg;
    assign out_word.base = base_reg;

endmodule

>>> hw/rtl/ffrs_log.sv
// normalize and squaring stages that form minus log2 of the base
module ffrs_log (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffrs_pkg::base_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ffrs_pkg::log_word_t  out_word
);
    import ffrs_pkg::*;

    logic [LOG_STAGES-1:0] valid_reg;
    logic [LOG_STAGES:0]   ready_chain;

    logic [30:0] m_reg     [LOG_STAGES];
    logic [30:0] m_next    [LOG_STAGES];
    logic [15:0] frac_reg  [LOG_STAGES];
    logic [15:0] frac_next [LOG_STAGES];
    logic [4:0]  q_reg     [LOG_STAGES];
    logic [4:0]  q_next    [LOG_STAGES];
    logic        zero_reg  [LOG_STAGES];
    logic        zero_next [LOG_STAGES];
    logic [61:0] sq        [1:LOG_STAGES-1];
    logic [16:0] base_nz;
    logic [4:0]  msb_pos;

    always_comb
    begin
        ready_chain[LOG_STAGES] = out_ready;
        for (int s = LOG_STAGES - 1; s >= 0; s--)
        begin
            ready_chain[s] = !valid_reg[s] || ready_chain[s+1];
        end
    end

    assign in_ready = ready_chain[0];

    always_comb
    begin
        // zero base is flagged, a dummy base of one keeps the mantissa clean
        base_nz = in_word.zero ? 17'd1 : in_word.base;
        msb_pos = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (base_nz[i])
            begin
                msb_pos = 5'(i);
            end
        end
        m_next[0]    = 31'(base_nz) << (5'd30 - msb_pos);
        frac_next[0] = '0;
        q_next[0]    = msb_pos;
        zero_next[0] = in_word.zero;
        for (int s = 1; s < LOG_STAGES; s++)
        begin
            sq[s] = 62'(m_reg[s-1]) * 62'(m_reg[s-1]);
            if (sq[s][61])
            begin
                m_next[s]    = sq[s][61:31];
                frac_next[s] = {frac_reg[s-1][14:0], 1'b1};
            end
            else
            begin
                m_next[s]    = sq[s][60:30];
                frac_next[s] = {frac_reg[s-1][14:0], 1'b0};
            end
            q_next[s]    = q_reg[s-1];
            zero_next[s] = zero_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < LOG_STAGES; s++)
            begin
                if (ready_chain[s])
                begin
                    valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < LOG_STAGES; s++)
        begin
            if (ready_chain[s])
            begin
                m_reg[s]    <= m_next[s];
                frac_reg[s] <= frac_next[s];
                q_reg[s]    <= q_next[s];
                zero_reg[s] <= zero_next[s];
            end
        end
    end

    assign out_valid     = valid_reg[LOG_STAGES-1];
    assign out_word.zero = zero_reg[LOG_STAGES-1];
    assign out_word.neg  = {5'd16 - q_reg[LOG_STAGES-1], 16'h0000}
                         - {5'd0, frac_reg[LOG_STAGES-1]};

    a_norm_entry: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> m_reg[0][30])
        else $error("mantissa not normalized after leading one search");

    a_norm_exit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LOG_STAGES-1] |-> m_reg[LOG_STAGES-1][30])
        else $error("mantissa left its range in the squaring stages");

endmodule

>>> hw/rtl/ffrs_exp.sv
// exponent scaling and exp2 stages that form the fresnel term
module ffrs_exp (
    input  logic                clk,
    input  logic                rst_n,
    input  ffrs_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffrs_pkg::log_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [30:0]         fresnel
);
    import ffrs_pkg::*;

    logic [EXP_STAGES-1:0] valid_reg;
    logic [EXP_STAGES:0]   ready_chain;

    logic [7:0]  k_reg     [EXP_MUL+1];
    logic [7:0]  k_next    [EXP_MUL+1];
    logic [15:0] f_reg     [EXP_MUL+1];
    logic [15:0] f_next    [EXP_MUL+1];
    logic        zero_reg  [EXP_MUL+1];
    logic        zero_next [EXP_MUL+1];
    logic [30:0] acc_reg   [1:EXP_MUL];
    logic [30:0] acc_next  [1:EXP_MUL];
    logic [30:0] acc_in    [1:EXP_MUL];
    logic [61:0] mul       [1:EXP_MUL];
    logic [36:0] scale_prod;
    logic [23:0] scaled;
    logic [30:0] fresnel_reg;
    logic [30:0] fresnel_next;

    always_comb
    begin
        ready_chain[EXP_STAGES] = out_ready;
        for (int s = EXP_STAGES - 1; s >= 0; s--)
        begin
            ready_chain[s] = !valid_reg[s] || ready_chain[s+1];
        end
    end

    assign in_ready = ready_chain[0];

    always_comb
    begin
        scale_prod   = 37'(cfg.sharpness_exponent) * 37'(in_word.neg);
        scaled       = scale_prod[35:12];
        k_next[0]    = scaled[23:16];
        f_next[0]    = scaled[15:0];
        zero_next[0] = in_word.zero && (cfg.sharpness_exponent != '0);
        acc_in[1]    = ACC_ONE;
        for (int s = 2; s <= EXP_MUL; s++)
        begin
            acc_in[s] = acc_reg[s-1];
        end
        for (int s = 1; s <= EXP_MUL; s++)
        begin
            mul[s]       = 62'(acc_in[s]) * 62'(EXP2_COEF[s]);
            acc_next[s]  = f_reg[s-1][16-s] ? mul[s][60:30] : acc_in[s];
            k_next[s]    = k_reg[s-1];
            f_next[s]    = f_reg[s-1];
            zero_next[s] = zero_reg[s-1];
        end
        if (zero_reg[EXP_MUL] || (k_reg[EXP_MUL] >= 8'd31))
        begin
            fresnel_next = '0;
        end
        else
        begin
            fresnel_next = acc_reg[EXP_MUL] >> k_reg[EXP_MUL][4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < EXP_STAGES; s++)
            begin
                if (ready_chain[s])
                begin
                    valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= EXP_MUL; s++)
        begin
            if (ready_chain[s])
            begin
                k_reg[s]    <= k_next[s];
                f_reg[s]    <= f_next[s];
                zero_reg[s] <= zero_next[s];
            end
        end
        for (int s = 1; s <= EXP_MUL; s++)
        begin
            if (ready_chain[s])
            begin
                acc_reg[s] <= acc_next[s];
            end
        end
        if (ready_chain[EXP_STAGES-1])
        begin
            fresnel_reg <= fresnel_next;
        end
    end

    assign out_valid = valid_reg[EXP_STAGES-1];
    assign fresnel   = fresnel_reg;

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[EXP_MUL] |-> (acc_reg[EXP_MUL] <= ACC_ONE))
        else $error("exp2 accumulator grew above one");

endmodule

>>> hw/rtl/ffrs_color.sv
// strength and color scaling with output saturation
module ffrs_color (
    input  logic           clk,
    input  logic           rst_n,
    input  ffrs_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [30:0]    fresnel,
    output logic           out_valid,
    input  logic           out_ready,
    output ffrs_pkg::rgb_t out_word
);
    import ffrs_pkg::*;

    logic [COLOR_STAGES-1:0] valid_reg;
    logic [COLOR_STAGES:0]   ready_chain;

    logic [46:0] fs_reg;
    logic [46:0] fs_next;
    logic [62:0] red_reg;
    logic [62:0] red_next;
    logic [62:0] green_reg;
    logic [62:0] green_next;
    logic [62:0] blue_reg;
    logic [62:0] blue_next;
    rgb_t        rgb_reg;
    rgb_t        rgb_next;

    always_comb
    begin
        ready_chain[COLOR_STAGES] = out_ready;
        for (int s = COLOR_STAGES - 1; s >= 0; s--)
        begin
            ready_chain[s] = !valid_reg[s] || ready_chain[s+1];
        end
    end

    assign in_ready = ready_chain[0];

    always_comb
    begin
        fs_next    = 47'(fresnel) * 47'(cfg.strength);
        red_next   = 63'(fs_reg) * 63'(cfg.color_red);
        green_next = 63'(fs_reg) * 63'(cfg.color_green);
        blue_next  = 63'(fs_reg) * 63'(cfg.color_blue);
        rgb_next.fuzz_red   = (|red_reg[62:58])   ? 16'hFFFF : red_reg[57:42];
        rgb_next.fuzz_green = (|green_reg[62:58]) ? 16'hFFFF : green_reg[57:42];
        rgb_next.fuzz_blue  = (|blue_reg[62:58])  ? 16'hFFFF : blue_reg[57:42];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready_chain[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (ready_chain[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (ready_chain[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_chain[0])
        begin
            fs_reg <= fs_next;
        end
        if (ready_chain[1])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
        if (ready_chain[2])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg[COLOR_STAGES-1];
    assign out_word  = rgb_reg;

endmodule

>>> tb/fresnel_fuzz_rim_shade_checker.sv
// fuzz rim shade checker: mirrors the registers, predicts each shade and compares results
module fresnel_fuzz_rim_shade_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ffrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ffrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [15:0]               normal_x,
    input  logic signed [15:0]               normal_y,
    input  logic signed [15:0]               normal_z,
    input  logic signed [15:0]               view_x,
    input  logic signed [15:0]               view_y,
    input  logic signed [15:0]               view_z,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [15:0]                      fuzz_red,
    input  logic [15:0]                      fuzz_green,
    input  logic [15:0]                      fuzz_blue,
    output int                               fail_count,
    output int                               pending,
    output int                               checked
);
    import ffrs_pkg::*;

    cfg_t        regs;
    rgb_t        shade_queue[$];
    logic [63:0] exp_root [1:16];
    int          mismatches = 0;
    sample_t     seen_sample;
    rgb_t        seen_shade;

    assign seen_sample = {normal_x, normal_y, normal_z, view_x, view_y, view_z};
    assign seen_shade  = {fuzz_red, fuzz_green, fuzz_blue};
    assign fail_count  = mismatches + pending;

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // q.30 roots of one half, each the square root of the one before
    initial
    begin
        logic [63:0] c;
        c = floor_sqrt(64'd1 << 59);
        for (int i = 1; i <= 16; i++)
        begin
            exp_root[i] = c;
            c = floor_sqrt(c << 30);
        end
    end

    function automatic logic [15:0] tint(logic [63:0] fres, logic [15:0] gain,
                                         logic [15:0] color);
        logic [63:0] v;
        v = (fres * gain * color) >> 42;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic rgb_t rim_shade(sample_t s, cfg_t c);
        logic signed [63:0] dot;
        logic [16:0]        base;
        logic [63:0]        mant;
        logic [63:0]        neglog;
        logic [63:0]        y;
        logic [63:0]        acc;
        logic [63:0]        fres;
        logic [15:0]        frac;
        int                 msb;
        rgb_t               r;
        dot = $signed(s.normal_x) * $signed(s.view_x)
            + $signed(s.normal_y) * $signed(s.view_y)
            + $signed(s.normal_z) * $signed(s.view_z);
        if (dot <= 0)
            base = 17'h10000;
        else if (dot >= 64'sd1073741824)
            base = '0;
        else
            base = 17'h10000 - {1'b0, dot[29:14]};

        if (c.sharpness_exponent == '0)
            fres = 64'd1 << 30;
        else if (base == '0)
            fres = '0;
        else
        begin
            msb = 16;
            while (msb > 0 && !base[msb])
                msb--;
            mant = 64'(base) << (30 - msb);
            frac = '0;
            for (int i = 0; i < 16; i++)
            begin
                mant = (mant * mant) >> 30;
                frac = frac << 1;
                if (mant >= 64'h8000_0000)
                begin
                    mant = mant >> 1;
                    frac[0] = 1'b1;
                end
            end
            neglog = (64'(16 - msb) << 16) - 64'(frac);
            y = (64'(c.sharpness_exponent) * neglog) >> 12;
            acc = 64'd1 << 30;
            for (int i = 1; i <= 16; i++)
                if (y[16 - i])
                    acc = (acc * exp_root[i]) >> 30;
            fres = (y[63:16] >= 31) ? 64'd0 : (acc >> y[63:16]);
        end

        r.fuzz_red   = tint(fres, c.strength, c.color_red);
        r.fuzz_green = tint(fres, c.strength, c.color_green);
        r.fuzz_blue  = tint(fres, c.strength, c.color_blue);
        return r;
    endfunction

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [2:0][15:0] want;
        logic [2:0][15:0] got;
        string            chan [3];
        if (!rst_n)
        begin
            regs <= '{COLOR_RESET, COLOR_RESET, COLOR_RESET, STRENGTH_RESET,
                      EXPONENT_RESET};
            shade_queue.delete();
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            chan = '{"blue", "green", "red"};
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COLOR_RED:   regs.color_red          <= cfg_data;
                    REG_COLOR_GREEN: regs.color_green        <= cfg_data;
                    REG_COLOR_BLUE:  regs.color_blue         <= cfg_data;
                    REG_STRENGTH:    regs.strength           <= cfg_data;
                    REG_EXPONENT:    regs.sharpness_exponent <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                shade_queue.push_back(rim_shade(seen_sample, regs));
            if (out_valid && out_ready)
            begin
                if (shade_queue.size() == 0)
                    flag($sformatf("unexpected word r=%0d g=%0d b=%0d",
                                   fuzz_red, fuzz_green, fuzz_blue));
                else
                begin
                    want = shade_queue.pop_front();
                    got  = seen_shade;
                    for (int f = 0; f < 3; f++)
                        if (got[f] != want[f])
                            flag($sformatf("%s expected %0d got %0d",
                                           chan[f], want[f], got[f]));
                    checked <= checked + 1;
                end
            end
            pending <= shade_queue.size();
        end
    end

endmodule

>>> tb/fresnel_fuzz_rim_shade_unit_tb.sv
// fuzz rim shade testbench: reset, register settings, directed and random samples, verdict
module fresnel_fuzz_rim_shade_unit_tb;

    import ffrs_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [15:0]     normal_x;
    logic signed [15:0]     normal_y;
    logic signed [15:0]     normal_z;
    logic signed [15:0]     view_x;
    logic signed [15:0]     view_y;
    logic signed [15:0]     view_z;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [15:0]            fuzz_red;
    logic [15:0]            fuzz_green;
    logic [15:0]            fuzz_blue;
    int                     fail_count;
    int                     pending;
    int                     checked;

    int send_idle = 0;
    int stall_pct = 0;
    int sent = 0;
    int settings = 0;

    fresnel_fuzz_rim_shade_unit dut (.*);

    fresnel_fuzz_rim_shade_checker checker_i (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic sample_t aim(int nx, int ny, int nz, int vx, int vy, int vz);
        return {16'(nx), 16'(ny), 16'(nz), 16'(vx), 16'(vy), 16'(vz)};
    endfunction

    task automatic send(sample_t s);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        normal_x <= s.normal_x;
        normal_y <= s.normal_y;
        normal_z <= s.normal_z;
        view_x   <= s.view_x;
        view_y   <= s.view_y;
        view_z   <= s.view_z;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_all(cfg_t v);
        cfg_write <= 1'b1;
        for (int i = REG_COLOR_RED; i <= REG_EXPONENT; i++)
        begin
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= v[(REG_EXPONENT - i) * CFG_DATA_W +: CFG_DATA_W];
            @(posedge clk);
        end
        // unmapped indexes must leave every register alone
        for (int i = REG_EXPONENT + 1; i < 2 ** CFG_INDEX_W; i++)
        begin
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings++;
    endtask

    initial
    begin
        cfg_t    setting;
        sample_t s;
        int      nx, ny, nz, a, v;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        normal_x  = '0;
        normal_y  = '0;
        normal_z  = '0;
        view_x    = '0;
        view_y    = '0;
        view_z    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        settings = 1;

        // reset settings: facing, grazing, saturation and underflow corners
        send(aim(0, 0, 32767, 0, 0, -32768));
        send(aim(32767, 0, 0, 0, 32767, 0));
        send(aim(32767, 0, 0, 32767, 0, 0));
        send(aim(-32768, -32768, -32768, -32768, -32768, -32768));
        send(aim(-32768, 0, 0, -32768, 0, 0));
        send(aim(32767, -32768, 32767, -32768, 32767, -32768));
        send(aim(1, 0, 0, 1, 0, 0));
        send(aim(128, 0, 0, 128, 0, 0));
        send(aim(23170, 0, 0, 23170, 0, 0));
        send(aim(32767, 32767, 0, 32767, 2, 0));
        send(aim(0, 30000, 0, 0, 30000, 0));
        send(aim(18918, 18918, 18918, 16000, 17000, 15000));
        send(aim(-1, -1, -1, -1, -1, -1));
        send(aim(0, 0, 0, 0, 0, 0));
        settle();

        setting = '{COLOR_RESET, COLOR_RESET, COLOR_RESET, STRENGTH_RESET, 16'd0};
        set_all(setting);
        send(aim(-32768, 0, 0, -32768, 0, 0));
        send(aim(32767, 32767, 0, 32767, 2, 0));
        send(aim(0, 0, 32767, 0, 0, -32768));
        settle();

        setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        set_all(setting);
        send(aim(0, 0, 32767, 0, 0, -32768));
        send(aim(23170, 0, 0, 23170, 0, 0));
        send(aim(1, 0, 0, 1, 0, 0));
        send(aim(-32768, -32768, -32768, -32768, -32768, -32768));
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 77; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 77; end
                default: begin send_idle = 35; stall_pct = 35; end
            endcase
            setting = '{16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(8191)), 16'($urandom)};
            case (ph)
                0:
                begin
                    setting.strength           = STRENGTH_RESET;
                    setting.sharpness_exponent = EXPONENT_RESET;
                end
                1: setting.sharpness_exponent = 16'd1;
                2: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                3: setting.sharpness_exponent = 16'($urandom_range(8191));
                4: setting.strength = '0;
                5:
                begin
                    setting.color_red   = '0;
                    setting.color_green = 16'hFFFF;
                end
                6: setting.sharpness_exponent = '0;
                default: setting.strength = 16'($urandom);
            endcase
            set_all(setting);

            for (int n = 0; n < 134; n++)
            begin
                if (ph == 3 && n == 67)
                    settle();
                case ($urandom_range(19))
                    0, 1, 2, 3:
                        s = {16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)};
                    4, 5, 6, 7, 8, 9, 10:
                    begin
                        // normal of length at most one with a nearby view direction
                        nx = int'($urandom_range(37836)) - 18918;
                        ny = int'($urandom_range(37836)) - 18918;
                        nz = int'($urandom_range(37836)) - 18918;
                        s = aim(nx, ny, nz,
                                nx + int'($urandom_range(12000)) - 6000,
                                ny + int'($urandom_range(12000)) - 6000,
                                nz + int'($urandom_range(12000)) - 6000);
                    end
                    11, 12, 13, 14, 15, 16, 17:
                    begin
                        // both vectors on one axis, same sign
                        a = int'($urandom_range(32767));
                        v = int'($urandom_range(32767));
                        if ($urandom_range(1))
                        begin
                            a = -a;
                            v = -v;
                        end
                        case ($urandom_range(2))
                            0: s = aim(a, 0, 0, v, 0, 0);
                            1: s = aim(0, a, 0, 0, v, 0);
                            default: s = aim(0, 0, a, 0, 0, v);
                        endcase
                    end
                    default:
                        s = aim(int'($urandom_range(600)) - 300,
                                int'($urandom_range(600)) - 300,
                                int'($urandom_range(600)) - 300,
                                int'($urandom_range(600)) - 300,
                                int'($urandom_range(600)) - 300,
                                int'($urandom_range(600)) - 300);
                endcase
                send(s);
            end
            settle();
        end

        repeat (60) @(posedge clk);
        $display("covered %0d samples under %0d register settings and four idle mixes",
                 sent, settings);
        $display("%0d shade words compared field by field", checked);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
